FILE: design/assert_macros.svh
// assertion macros shared by the interpolator modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define KVI_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define KVI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/kvi_pkg.sv
// types and constants for the keyframe vector interpolator
// no dependencies
package kvi_pkg;

    localparam int unsigned FRAC_BITS = 16;

    typedef struct packed {
        logic        kind;
        logic [5:0]  key_index;
        logic [31:0] key_time;
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
        logic [31:0] query_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [1:0]  region;
    } t_out_item;

    localparam logic       KIND_WRITE = 1'b0;
    localparam logic       KIND_QUERY = 1'b1;
    localparam logic [1:0] REGION_FIRST  = 2'd0;
    localparam logic [1:0] REGION_INTERP = 2'd1;
    localparam logic [1:0] REGION_LAST   = 2'd2;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;

endpackage

FILE: design/kvi_divider.sv
// restoring divider, one quotient bit per cycle, 48-bit dividend by 32-bit divisor
// depends on kvi_pkg
module kvi_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_dividend,
    input  logic [31:0] i_divisor,
    output kvi_pkg::t_div_ctl o_ctl,
    output logic [16:0] o_quot
);
    import kvi_pkg::*;

    logic [47:0] r_num, n_num;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, r_done;
    logic [32:0] w_trial;

    always_comb begin
        w_trial = {r_rem[31:0], r_num[47]};
        n_num = {r_num[46:0], 1'b0};
        n_rem = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial - {1'b0, r_den};
            n_num[0] = 1'b1;
        end
        n_cnt = r_cnt - 6'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd48;
                r_num  <= i_dividend;
                r_den  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= n_num;
                r_rem <= n_rem;
                r_cnt <= n_cnt;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;
    assign o_quot      = r_num[16:0];

`include "assert_macros.svh"
    `KVI_ASSERT_NEXT(a_done_after_busy, i_clk, i_rst_n, r_done, !r_busy, "divider busy after done")
    `KVI_ASSERT(a_cnt_range, i_clk, i_rst_n, r_busy, r_cnt != 6'd0 && r_cnt <= 6'd48, "divider count out of range")
endmodule

FILE: design/kvi_blend.sv
// one component blend v0 + floor((v1 - v0) * t / 65536), two registered stages
// depends on kvi_pkg
module kvi_blend (
    input  logic        i_clk,
    input  logic signed [31:0] i_v0,
    input  logic signed [31:0] i_v1,
    input  logic [16:0] i_t,
    output logic signed [31:0] o_res
);
    import kvi_pkg::*;

    logic signed [32:0] r_diff;
    logic signed [31:0] r_v0;
    logic signed [50:0] r_prod;
    logic signed [31:0] r_base;
    logic signed [50:0] w_sum;

    always_ff @(posedge i_clk) begin
        r_diff <= 33'(i_v1) - 33'(i_v0);
        r_v0   <= i_v0;
        r_prod <= 51'(r_diff) * 51'(signed'({1'b0, i_t}));
        r_base <= r_v0;
    end

    assign w_sum = 51'(r_base) + (r_prod >>> FRAC_BITS);
    assign o_res = w_sum[31:0];
endmodule

FILE: design/keyframe_vector_interpolator.sv
// channel   direction  handshake                  payload
// item in   in         start, busy                t_in_item
// config    in         i_cfg_valid, o_cfg_ready   7-bit key count
// result    out        o_done strobe              t_out_item
// a write goes straight into the key table; a query tests one segment after another, and
// when interpolating it uses the shared divider and then the blend pipelines
// the key table is a memory with one registered read port; search reads the keys in order
// reset clears the control state and sets the key count to 1; the table is not cleared
// results are strobed for one cycle and cannot be stalled
// depends on kvi_pkg, kvi_divider, kvi_blend
module keyframe_vector_interpolator #(
    parameter int unsigned MAX_KEYS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  kvi_pkg::t_in_item  i_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [6:0]         i_cfg_data,
    output logic               o_done,
    output kvi_pkg::t_out_item o_item
);
    import kvi_pkg::*;

    localparam int unsigned AW = $clog2(MAX_KEYS);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FIRST = 8'b0000_0010,
        S_RD0   = 8'b0000_0100,
        S_RD1   = 8'b0000_1000,
        S_CMP   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_BL    = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;
    logic [127:0] r_mem [MAX_KEYS];
    logic [127:0] r_rd;
    logic [AW-1:0] r_addr;
    logic [AW:0]   r_idx;
    logic [AW:0]   r_n;
    logic [6:0]    r_cfg;
    logic [31:0]   r_q;
    logic [127:0]  r_k0;
    logic [1:0]    r_bl_cnt;
    logic          r_done;
    t_out_item     r_out;
    logic          w_div_start;
    t_div_ctl      w_div;
    logic [16:0]   w_quot;
    logic [31:0]   w_rx, w_ry, w_rz;
    logic [31:0]   w_t0, w_t1;
    logic [AW:0]   w_n;

    always_comb begin
        if (r_cfg == 7'd0) w_n = (AW+1)'(1);
        else if ({25'd0, r_cfg} > 32'(MAX_KEYS)) w_n = (AW+1)'(MAX_KEYS);
        else w_n = (AW+1)'(r_cfg);
    end

    assign w_t0 = r_k0[127:96];
    assign w_t1 = r_rd[127:96];

    always_ff @(posedge i_clk) begin
        if (start && !busy && i_item.kind == KIND_WRITE
                && {26'd0, i_item.key_index} < 32'(MAX_KEYS))
            r_mem[AW'(i_item.key_index)] <= {i_item.key_time, i_item.value_x,
                                             i_item.value_y, i_item.value_z};
        r_rd <= r_mem[r_addr];
    end

    assign w_div_start = (r_state == S_CMP) && (r_idx != r_n)
                         && (w_t0 <= r_q) && (r_q <= w_t1) && (w_t1 != w_t0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= 7'd1;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_cfg <= i_cfg_data;
            unique case (r_state)
                S_IDLE: begin
                    if (start && i_item.kind == KIND_QUERY) begin
                        r_q     <= i_item.query_time;
                        r_n     <= w_n;
                        r_addr  <= '0;
                        r_state <= S_FIRST;
                    end
                end
                S_FIRST: r_state <= S_RD0;
                S_RD0: begin
                    r_k0 <= r_rd;
                    if (r_n == (AW+1)'(1) || r_q <= r_rd[127:96]) begin
                        r_out   <= {r_rd[95:0], REGION_FIRST};
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= (AW+1)'(1);
                        r_addr  <= AW'(1);
                        r_state <= S_RD1;
                    end
                end
                S_RD1: r_state <= S_CMP;
                S_CMP: begin
                    if (r_idx == r_n) begin
                        r_out   <= {r_k0[95:0], REGION_LAST};
                        r_state <= S_OUT;
                    end else if (w_t0 <= r_q && r_q <= w_t1) begin
                        if (w_t1 == w_t0) begin
                            r_out   <= {r_k0[95:0], REGION_INTERP};
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_k0  <= r_rd;
                        r_idx <= r_idx + 1'b1;
                        if (r_idx + 1'b1 != r_n) r_addr <= r_addr + 1'b1;
                        r_state <= S_RD1;
                    end
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_bl_cnt <= 2'd0;
                        r_state  <= S_BL;
                    end
                end
                S_BL: begin
                    r_bl_cnt <= r_bl_cnt + 2'd1;
                    if (r_bl_cnt == 2'd2) begin
                        r_out   <= {w_rx, w_ry, w_rz, REGION_INTERP};
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic [16:0] r_t;
    always_ff @(posedge i_clk) begin
        if (w_div.done) r_t <= w_quot;
    end

    kvi_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({r_q - w_t0, 16'd0}),
        .i_divisor  (w_t1 - w_t0),
        .o_ctl      (w_div),
        .o_quot     (w_quot)
    );

    kvi_blend u_bx (.i_clk(i_clk), .i_v0(r_k0[95:64]), .i_v1(r_rd[95:64]),
                    .i_t(r_t), .o_res(w_rx));
    kvi_blend u_by (.i_clk(i_clk), .i_v0(r_k0[63:32]), .i_v1(r_rd[63:32]),
                    .i_t(r_t), .o_res(w_ry));
    kvi_blend u_bz (.i_clk(i_clk), .i_v0(r_k0[31:0]), .i_v1(r_rd[31:0]),
                    .i_t(r_t), .o_res(w_rz));

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_done      = r_done;
    assign o_item      = r_out;

`include "assert_macros.svh"
    `KVI_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, r_state == S_OUT, r_done && r_state == S_IDLE, "result not strobed")
    `KVI_ASSERT(a_div_in_search, i_clk, i_rst_n, w_div.busy, r_state == S_DIV, "divider busy outside division")
    `KVI_ASSERT(a_idx_range, i_clk, i_rst_n, r_state == S_CMP, r_idx <= r_n && r_idx != '0, "search index out of range")
endmodule
